>>> rtl/local_magnitude_from_amplitude_assert.svh
// -----------------------------------------------------------------------------
// Local magnitude assertion macros
// Shared property forms for the checker of the local magnitude block.
// -----------------------------------------------------------------------------
`ifndef LOCAL_MAGNITUDE_FROM_AMPLITUDE_ASSERT_SVH
`define LOCAL_MAGNITUDE_FROM_AMPLITUDE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LMFA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LMFA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lmfa_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Local magnitude package
// Fixed-point constants, widths and status codes shared by the block.
// -----------------------------------------------------------------------------
package lmfa_pkg;

  localparam int unsigned DEG_W     = 24;
  localparam int unsigned KM_W      = 31;
  localparam int unsigned MANT_W    = 32;
  localparam int unsigned LOG_FRAC  = 24;
  localparam int unsigned CORR_W    = 35;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned MAG_W     = 17;
  localparam int unsigned KMUL_W    = 23;
  localparam int unsigned SLOPE_W   = 27;
  localparam int unsigned SEG_KM_W  = 26;
  localparam int unsigned L10_W     = 31;

  // 111.195 km per degree in Q16.
  localparam logic [KMUL_W-1:0] KM_PER_DEG_Q16 = 23'd7287276;

  // Segment limits in kilometres, Q16.
  localparam logic [KM_W-1:0] BREAK1_KM_Q16 = 31'd3932160;
  localparam logic [KM_W-1:0] BREAK2_KM_Q16 = 31'd26214400;
  localparam logic [KM_W-1:0] BREAK3_KM_Q16 = 31'd65536000;

  // Correction offsets and slopes, Q32.
  localparam logic [CORR_W-1:0]  OFF1_Q32   = 35'd5583457485;
  localparam logic [CORR_W-1:0]  OFF2_Q32   = 35'd10737418240;
  localparam logic [CORR_W-1:0]  OFF3_Q32   = 35'd15461882266;
  localparam logic [SLOPE_W-1:0] SLOPE1_Q32 = 27'd107374182;
  localparam logic [SLOPE_W-1:0] SLOPE2_Q32 = 27'd21474836;
  localparam logic [SLOPE_W-1:0] SLOPE3_Q32 = 27'd9663676;

  // log10(2) in Q32.
  localparam logic [L10_W-1:0] LOG10_2_Q32 = 31'd1292913986;

  // 64.0 in Q32 less 16 * log10(2) in Q32: removes the Q16 amplitude scale and
  // biases the sum so that the rounding shift sees a non-negative value.
  localparam logic [SUM_W-1:0] MAG_BIAS = 40'd254191283168;

  localparam int MAG_MAX = 65535;
  localparam int MAG_MIN = -65536;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_AMP_ZERO = 2'd1,
    ST_TOO_FAR  = 2'd2
  } lmfa_status_e;

endpackage

>>> rtl/local_magnitude_from_amplitude.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Local magnitude from amplitude
// Pipelined log10 of a peak amplitude plus a distance correction.
// -----------------------------------------------------------------------------
// Usage: each input word carries a peak amplitude (micrometres, Q16) and an
// epicentral distance (degrees, Q16) on a valid/ready channel. Each result
// word carries the magnitude (Q with MAG_FRAC_BITS fraction bits) and a
// status code on a second valid/ready channel, one result per input word,
// in order.
// Throughput is one word per cycle while the receiver does not stall. A word
// passes through 28 registers from acceptance to the result register: one
// stage normalises the amplitude and converts the distance, one forms the
// correction, 24 stages each square the log2 mantissa once (one 32 by 32
// multiplier per stage, which sets the depth), one scales log2 to log10 and
// the last rounds and clamps into the output register.
// Every stage has its own valid bit and takes a new word whenever it is
// empty or its successor takes its word, so a stalled receiver lets bubbles
// collapse and input is still taken until all stages hold a word.
// Reset empties all stages; no result is offered until a word has passed
// through. While the receiver stalls the result word holds steady.
// -----------------------------------------------------------------------------
module local_magnitude_from_amplitude import lmfa_pkg::*; #(
  parameter int unsigned AMP_WIDTH     = 40,
  parameter int unsigned MAG_FRAC_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [AMP_WIDTH-1:0]    amplitude_i,
  input  logic [DEG_W-1:0]        distance_deg_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [MAG_W-1:0] magnitude_o,
  output logic [1:0]              status_o
);

  localparam int unsigned PW        = $clog2(AMP_WIDTH);
  localparam int unsigned L_W       = PW + LOG_FRAC;
  localparam int unsigned LPROD_W   = L_W + L10_W;
  localparam int unsigned LVAL_W    = LPROD_W - LOG_FRAC;
  localparam int unsigned KPROD_W   = DEG_W + KMUL_W;
  localparam int unsigned SQ_STAGES = LOG_FRAC;

  // ---------------------------------------------------------------------------
  // Stage A: amplitude normalisation and degrees to kilometres.
  // ---------------------------------------------------------------------------
  logic                a_valid_q, a_rdy;
  logic [PW-1:0]       a_lead_d, a_lead_q;
  logic [MANT_W-1:0]   a_mant_d, a_mant_q;
  logic                a_zero_d, a_zero_q;
  logic [KPROD_W-1:0]  km_prod, km_sum;
  logic [KM_W-1:0]     a_km_q;

  lmfa_norm #(
    .AMP_WIDTH (AMP_WIDTH),
    .PW        (PW)
  ) u_norm (
    .amp_i  (amplitude_i),
    .lead_o (a_lead_d),
    .mant_o (a_mant_d),
    .zero_o (a_zero_d)
  );

  assign km_prod = {{KMUL_W{1'b0}}, distance_deg_i} * {{DEG_W{1'b0}}, KM_PER_DEG_Q16};
  assign km_sum  = km_prod + KPROD_W'(32768);

  // ---------------------------------------------------------------------------
  // Stage B: distance correction and status.
  // ---------------------------------------------------------------------------
  logic               b_valid_q, b_rdy;
  logic [PW-1:0]      b_lead_q;
  logic [MANT_W-1:0]  b_mant_q;
  logic [CORR_W-1:0]  b_corr_d, b_corr_q;
  logic               b_far;
  lmfa_status_e       b_status_d, b_status_q;

  lmfa_corr u_corr (
    .km_i   (a_km_q),
    .corr_o (b_corr_d),
    .far_o  (b_far)
  );

  // A zero amplitude is reported ahead of an excessive distance.
  always_comb begin
    if (a_zero_q) begin
      b_status_d = ST_AMP_ZERO;
    end else if (b_far) begin
      b_status_d = ST_TOO_FAR;
    end else begin
      b_status_d = ST_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // Squaring stages: one fraction bit of log2 each.
  // ---------------------------------------------------------------------------
  logic [SQ_STAGES-1:0] sq_valid_q, sq_rdy;
  logic [MANT_W-1:0]    sq_mant_in  [SQ_STAGES];
  logic [LOG_FRAC-1:0]  sq_frac_in  [SQ_STAGES];
  logic [MANT_W-1:0]    sq_mant_d   [SQ_STAGES];
  logic [LOG_FRAC-1:0]  sq_frac_d   [SQ_STAGES];
  logic [MANT_W-1:0]    sq_mant_q   [SQ_STAGES];
  logic [LOG_FRAC-1:0]  sq_frac_q   [SQ_STAGES];
  logic [PW-1:0]        sq_lead_q   [SQ_STAGES];
  logic [CORR_W-1:0]    sq_corr_q   [SQ_STAGES];
  lmfa_status_e         sq_status_q [SQ_STAGES];

  // ---------------------------------------------------------------------------
  // Stage C: log2 to log10. Stage D: rounding into the result register.
  // ---------------------------------------------------------------------------
  logic                    c_valid_q, c_rdy;
  logic [L_W-1:0]          c_log2;
  logic [LPROD_W-1:0]      c_prod, c_sum;
  logic [LVAL_W-1:0]       c_lval_q;
  logic [CORR_W-1:0]       c_corr_q;
  lmfa_status_e            c_status_q;

  logic                    d_valid_q, d_rdy;
  logic signed [MAG_W-1:0] d_mag_d, d_mag_q;
  lmfa_status_e            d_status_q;

  // Ready runs back from the result register: a stage may load when it is
  // empty or when its own word moves on in the same cycle.
  assign d_rdy                = !d_valid_q || out_ready_i;
  assign c_rdy                = !c_valid_q || d_rdy;
  assign sq_rdy[SQ_STAGES-1]  = !sq_valid_q[SQ_STAGES-1] || c_rdy;
  assign b_rdy                = !b_valid_q || sq_rdy[0];
  assign a_rdy                = !a_valid_q || b_rdy;
  assign in_ready_o           = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_valid_q <= in_valid_i;
      end
      if (b_rdy) begin
        b_valid_q <= a_valid_q;
      end
      if (c_rdy) begin
        c_valid_q <= sq_valid_q[SQ_STAGES-1];
      end
      if (d_rdy) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      a_lead_q <= a_lead_d;
      a_mant_q <= a_mant_d;
      a_zero_q <= a_zero_d;
      a_km_q   <= km_sum[KPROD_W-1:16];
    end
    if (b_rdy && a_valid_q) begin
      b_lead_q   <= a_lead_q;
      b_mant_q   <= a_mant_q;
      b_corr_q   <= b_corr_d;
      b_status_q <= b_status_d;
    end
  end

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sq
    logic              prev_valid;
    logic [PW-1:0]     prev_lead;
    logic [CORR_W-1:0] prev_corr;
    lmfa_status_e      prev_status;

    if (s == 0) begin : g_first
      assign prev_valid    = b_valid_q;
      assign prev_lead     = b_lead_q;
      assign prev_corr     = b_corr_q;
      assign prev_status   = b_status_q;
      assign sq_mant_in[s] = b_mant_q;
      assign sq_frac_in[s] = '0;
    end else begin : g_next
      assign prev_valid    = sq_valid_q[s-1];
      assign prev_lead     = sq_lead_q[s-1];
      assign prev_corr     = sq_corr_q[s-1];
      assign prev_status   = sq_status_q[s-1];
      assign sq_mant_in[s] = sq_mant_q[s-1];
      assign sq_frac_in[s] = sq_frac_q[s-1];
    end

    if (s < SQ_STAGES - 1) begin : g_rdy
      assign sq_rdy[s] = !sq_valid_q[s] || sq_rdy[s+1];
    end

    lmfa_sq_step u_sq (
      .mant_i (sq_mant_in[s]),
      .frac_i (sq_frac_in[s]),
      .mant_o (sq_mant_d[s]),
      .frac_o (sq_frac_d[s])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[s] <= 1'b0;
      end else if (sq_rdy[s]) begin
        sq_valid_q[s] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (sq_rdy[s] && prev_valid) begin
        sq_mant_q[s]   <= sq_mant_d[s];
        sq_frac_q[s]   <= sq_frac_d[s];
        sq_lead_q[s]   <= prev_lead;
        sq_corr_q[s]   <= prev_corr;
        sq_status_q[s] <= prev_status;
      end
    end
  end

  // log2 in Q24 is the leading-one position followed by the squared-out bits.
  assign c_log2 = {sq_lead_q[SQ_STAGES-1], sq_frac_q[SQ_STAGES-1]};
  assign c_prod = {{L10_W{1'b0}}, c_log2} * {{L_W{1'b0}}, LOG10_2_Q32};
  assign c_sum  = c_prod + (LPROD_W'(1) << (LOG_FRAC - 1));

  always_ff @(posedge clk_i) begin
    if (c_rdy && sq_valid_q[SQ_STAGES-1]) begin
      c_lval_q   <= c_sum[LPROD_W-1:LOG_FRAC];
      c_corr_q   <= sq_corr_q[SQ_STAGES-1];
      c_status_q <= sq_status_q[SQ_STAGES-1];
    end
  end

  lmfa_round #(
    .LVAL_W (LVAL_W),
    .FRAC_W (MAG_FRAC_BITS)
  ) u_round (
    .lval_i (c_lval_q),
    .corr_i (c_corr_q),
    .mag_o  (d_mag_d)
  );

  always_ff @(posedge clk_i) begin
    if (d_rdy && c_valid_q) begin
      d_mag_q    <= (c_status_q == ST_OK) ? d_mag_d : '0;
      d_status_q <= c_status_q;
    end
  end

  assign out_valid_o = d_valid_q;
  assign magnitude_o = d_mag_q;
  assign status_o    = d_status_q;

endmodule

>>> rtl/lmfa_norm.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Amplitude normaliser
// Finds the leading one of the amplitude and aligns it as a Q31 mantissa.
// -----------------------------------------------------------------------------
module lmfa_norm import lmfa_pkg::*; #(
  parameter int unsigned AMP_WIDTH = 40,
  parameter int unsigned PW        = 6
) (
  input  logic [AMP_WIDTH-1:0] amp_i,
  output logic [PW-1:0]        lead_o,
  output logic [MANT_W-1:0]    mant_o,
  output logic                 zero_o
);

  localparam logic [PW-1:0] TOP_IDX = PW'(AMP_WIDTH - 1);

  logic [AMP_WIDTH-1:0]        norm;
  logic [AMP_WIDTH+MANT_W-1:0] ext;
  logic [PW-1:0]               sh;

  // Highest set bit wins; an all-zero word gives position zero.
  always_comb begin
    lead_o = '0;
    for (int i = 0; i < AMP_WIDTH; i++) begin
      if (amp_i[i]) begin
        lead_o = PW'(i);
      end
    end
  end

  assign sh     = TOP_IDX - lead_o;
  assign norm   = amp_i << sh;
  assign ext    = {norm, {MANT_W{1'b0}}};
  assign mant_o = ext[AMP_WIDTH+MANT_W-1 -: MANT_W];
  assign zero_o = (amp_i == '0);

endmodule

>>> rtl/lmfa_corr.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Distance correction
// Three-segment linear correction in Q32 from a distance in kilometres, Q16.
// -----------------------------------------------------------------------------
module lmfa_corr import lmfa_pkg::*; (
  input  logic [KM_W-1:0]   km_i,
  output logic [CORR_W-1:0] corr_o,
  output logic              far_o
);

  localparam int unsigned PROD_W = SLOPE_W + SEG_KM_W;

  logic [SLOPE_W-1:0] slope;
  logic [CORR_W-1:0]  offset;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  prod_rnd;

  always_comb begin
    if (km_i <= BREAK1_KM_Q16) begin
      slope  = SLOPE1_Q32;
      offset = OFF1_Q32;
    end else if (km_i <= BREAK2_KM_Q16) begin
      slope  = SLOPE2_Q32;
      offset = OFF2_Q32;
    end else begin
      slope  = SLOPE3_Q32;
      offset = OFF3_Q32;
    end
  end

  // Only distances up to the last limit reach the output, and those fit in
  // the lower bits of the distance.
  assign prod     = {{SEG_KM_W{1'b0}}, slope} * {{SLOPE_W{1'b0}}, km_i[SEG_KM_W-1:0]};
  assign prod_rnd = prod + PROD_W'(32768);
  assign corr_o   = offset + CORR_W'(prod_rnd[PROD_W-1:16]);
  assign far_o    = (km_i > BREAK3_KM_Q16);

endmodule

>>> rtl/lmfa_sq_step.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Logarithm squaring step
// Squares the mantissa once and yields one more fraction bit of log2.
// -----------------------------------------------------------------------------
module lmfa_sq_step import lmfa_pkg::*; (
  input  logic [MANT_W-1:0]   mant_i,
  input  logic [LOG_FRAC-1:0] frac_i,
  output logic [MANT_W-1:0]   mant_o,
  output logic [LOG_FRAC-1:0] frac_o
);

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_q31;
  logic                bit_one;

  assign sq      = {{MANT_W{1'b0}}, mant_i} * {{MANT_W{1'b0}}, mant_i};
  assign sq_q31  = sq[2*MANT_W-1:MANT_W-1];
  assign bit_one = sq_q31[MANT_W];

  // A square of two or more sets the bit and halves the mantissa.
  assign mant_o = bit_one ? sq_q31[MANT_W:1] : sq_q31[MANT_W-1:0];
  assign frac_o = {frac_i[LOG_FRAC-2:0], bit_one};

endmodule

>>> rtl/lmfa_round.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Magnitude rounding
// Sums log10 and correction, rounds half up and clamps to the output range.
// -----------------------------------------------------------------------------
module lmfa_round import lmfa_pkg::*; #(
  parameter int unsigned LVAL_W = 37,
  parameter int unsigned FRAC_W = 12
) (
  input  logic [LVAL_W-1:0]       lval_i,
  input  logic [CORR_W-1:0]       corr_i,
  output logic signed [MAG_W-1:0] mag_o
);

  localparam int unsigned SHIFT = 32 - FRAC_W;
  localparam int unsigned RND_W = SUM_W - SHIFT;
  localparam int unsigned R_W   = RND_W + 2;
  localparam logic [SUM_W-1:0]     HALF   = SUM_W'(1) << (SHIFT - 1);
  localparam logic signed [R_W-1:0] OFFSET = R_W'(64) << FRAC_W;
  localparam logic signed [R_W-1:0] HI     = R_W'(MAG_MAX);
  localparam logic signed [R_W-1:0] LO     = R_W'(MAG_MIN);

  logic [SUM_W-1:0]      sum;
  logic [RND_W-1:0]      rounded;
  logic signed [R_W-1:0] r;

  assign sum     = SUM_W'(lval_i) + SUM_W'(corr_i) + MAG_BIAS + HALF;
  assign rounded = sum[SUM_W-1:SHIFT];
  assign r       = $signed({2'b00, rounded}) - OFFSET;

  always_comb begin
    if (r > HI) begin
      mag_o = MAG_W'(HI);
    end else if (r < LO) begin
      mag_o = MAG_W'(LO);
    end else begin
      mag_o = MAG_W'(r);
    end
  end

endmodule

>>> rtl/lmfa_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Local magnitude checker
// Port-level properties of the local magnitude block, bound to its top level.
// -----------------------------------------------------------------------------
`include "local_magnitude_from_amplitude_assert.svh"

module lmfa_checker import lmfa_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [MAG_W-1:0] magnitude_o,
  input logic [1:0]              status_o
);

  // A rejected word always reports a zero magnitude.
  `LMFA_ASSERT_IMP(a_err_mag_zero, out_valid_o && (status_o != ST_OK), magnitude_o == '0, "error word with non-zero magnitude")

  // The input side is only held off by a stalled result.
  `LMFA_ASSERT_IMP(a_ready_unless_stall, !out_valid_o || out_ready_i, in_ready_o, "input not ready without a stalled result")

  // A stalled result stays offered and unchanged.
  `LMFA_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(magnitude_o) && $stable(status_o), "stalled result changed")

endmodule

bind local_magnitude_from_amplitude lmfa_checker u_lmfa_checker (.*);

>>> dv/local_magnitude_from_amplitude_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Local magnitude testbench
// Drives amplitude and distance words into the magnitude block and checks
// every result word against a bit-exact fixed-point model held in this file.
// -----------------------------------------------------------------------------
// A short table of directed words covers the amplitude extremes, the leading
// one on both sides of the mantissa shift, each correction segment and its
// breakpoints, and both error codes. Random words follow in three handshake
// mixes. The third mix opens with a long output stall, so that the pipeline
// fills and pushes back on the input, and later pauses the input until all
// results are home.
// -----------------------------------------------------------------------------
module local_magnitude_from_amplitude_tb;
  import lmfa_pkg::*;

  localparam int unsigned AMP_W     = 40;
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned LIMIT     = 200000;
  localparam int unsigned DRAIN     = 40;
  localparam int unsigned PHASE_N   = 383;

  // Fixed-point constants of the magnitude formula, held apart from the RTL.
  localparam longint unsigned KM_Q16      = 64'd7287276;
  localparam longint unsigned LIM1_KM     = 64'd60 << 16;
  localparam longint unsigned LIM2_KM     = 64'd400 << 16;
  localparam longint unsigned LIM3_KM     = 64'd1000 << 16;
  localparam longint unsigned SEG1_OFF    = 64'd5583457485;
  localparam longint unsigned SEG2_OFF    = 64'd10737418240;
  localparam longint unsigned SEG3_OFF    = 64'd15461882266;
  localparam longint unsigned SEG1_SLOPE  = 64'd107374182;
  localparam longint unsigned SEG2_SLOPE  = 64'd21474836;
  localparam longint unsigned SEG3_SLOPE  = 64'd9663676;
  localparam longint unsigned LG2_Q32     = 64'd1292913986;
  localparam longint          Q16_SCALE   = 64'sd20686623776;
  localparam longint          MAG_TOP     = 64'sd65535;
  localparam longint          MAG_BOTTOM  = -64'sd65536;

  typedef struct packed {
    logic signed [MAG_W-1:0] magnitude;
    lmfa_status_e            status;
  } ml_result_t;

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic [DEG_W-1:0] deg;
    bit               typed;
    ml_result_t       want;
  } dir_row_t;

  localparam ml_result_t NO_TYPED = '{17'sd0, ST_OK};
  localparam ml_result_t ZERO_AMP = '{17'sd0, ST_AMP_ZERO};
  localparam ml_result_t TOO_FAR  = '{17'sd0, ST_TOO_FAR};

  // Directed words. Only the error rows carry a typed-in result; the rest are
  // checked against the model below.
  localparam int N_DIR = 19;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{40'd0,             24'd0,        1'b1, ZERO_AMP},
    '{40'd0,             24'hFFFFFF,   1'b1, ZERO_AMP},  // amplitude wins over distance
    '{40'hFFFFFFFFFF,    24'hFFFFFF,   1'b1, TOO_FAR},
    '{40'd1,             24'd11796480, 1'b1, TOO_FAR},   // 180 degrees
    '{40'd1,             24'd0,        1'b0, NO_TYPED},
    '{40'hFFFFFFFFFF,    24'd0,        1'b0, NO_TYPED},
    '{40'd65536,         24'd0,        1'b0, NO_TYPED},  // exactly one micrometre
    '{40'd65536,         24'd589378,   1'b0, NO_TYPED},  // last distance in range
    '{40'd65536,         24'd589379,   1'b0, NO_TYPED},  // first distance beyond
    '{40'h0080000000,    24'd35362,    1'b0, NO_TYPED},  // either side of 60 km
    '{40'h0100000000,    24'd35363,    1'b0, NO_TYPED},
    '{40'h007FFFFFFF,    24'd235752,   1'b0, NO_TYPED},  // both just beyond 400 km
    '{40'h0100000001,    24'd235753,   1'b0, NO_TYPED},
    '{40'hAAAAAAAAAA,    24'h05AAAA,   1'b0, NO_TYPED},
    '{40'h5555555555,    24'h015555,   1'b0, NO_TYPED},
    '{40'h8000000000,    24'd589378,   1'b0, NO_TYPED},
    '{40'd3,             24'd1,        1'b0, NO_TYPED},
    '{40'h00FFFFFFFF,    24'd400000,   1'b0, NO_TYPED},
    '{40'd2,             24'd100000,   1'b0, NO_TYPED}
  };

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic [AMP_W-1:0]        amplitude    = '0;
  logic [DEG_W-1:0]        distance_deg = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic signed [MAG_W-1:0] magnitude;
  logic [1:0]              status;

  // Side band that travels with the driven word: a typed-in result, if any.
  bit                      typed_row    = 1'b0;
  ml_result_t              typed_want   = NO_TYPED;

  ml_result_t              magnitude_due_q [$];
  ml_result_t              oldest_due;
  int unsigned             send_gap_pct = 0;
  int unsigned             recv_gap_pct = 0;
  int unsigned             hold_cycles  = 0;
  int unsigned             fail_cnt     = 0;
  int unsigned             words_in     = 0;
  int unsigned             words_out    = 0;
  int unsigned             n_valid      = 0;
  int unsigned             n_zero_amp   = 0;
  int unsigned             n_too_far    = 0;
  int unsigned             cycle_cnt    = 0;

  local_magnitude_from_amplitude #(
    .AMP_WIDTH    (AMP_W),
    .MAG_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .amplitude_i   (amplitude),
    .distance_deg_i(distance_deg),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .magnitude_o   (magnitude),
    .status_o      (status)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // log2 of the raw amplitude integer in Q24. The leading one gives the whole
  // part; the mantissa is normalised to Q31 in [1,2) and each squaring yields
  // one more fraction bit, taken when the square reaches 2.0.
  function automatic longint unsigned amp_log2_q24(logic [AMP_W-1:0] a);
    int              msb;
    longint unsigned mant;
    longint unsigned frac;
    msb = 0;
    for (int i = 0; i < AMP_W; i++) begin
      if (a[i]) begin
        msb = i;
      end
    end
    if (msb <= 31) begin
      mant = longint'(a) << (31 - msb);
    end else begin
      mant = longint'(a) >> (msb - 31);
    end
    frac = 0;
    repeat (24) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        mant = mant >> 1;
      end
    end
    return (longint'(msb) << 24) | frac;
  endfunction

  // Magnitude of one word: log10 of the amplitude plus the distance correction,
  // all in Q32, then rounded half up to FRAC_BITS and clamped.
  function automatic ml_result_t richter_ml(logic [AMP_W-1:0] amp,
                                            logic [DEG_W-1:0] deg);
    ml_result_t      res;
    longint unsigned km;
    longint unsigned corr;
    longint unsigned log10_q32;
    longint          sum_q32;
    longint unsigned biased;
    longint          rounded;
    res = '{17'sd0, ST_OK};
    if (amp == '0) begin
      res.status = ST_AMP_ZERO;
      return res;
    end
    km = (longint'(deg) * KM_Q16 + 64'd32768) >> 16;
    if (km > LIM3_KM) begin
      res.status = ST_TOO_FAR;
      return res;
    end
    if (km <= LIM1_KM) begin
      corr = SEG1_OFF + ((SEG1_SLOPE * km + 64'd32768) >> 16);
    end else if (km <= LIM2_KM) begin
      corr = SEG2_OFF + ((SEG2_SLOPE * km + 64'd32768) >> 16);
    end else begin
      corr = SEG3_OFF + ((SEG3_SLOPE * km + 64'd32768) >> 16);
    end
    log10_q32 = (amp_log2_q24(amp) * LG2_Q32 + (64'd1 << 23)) >> 24;
    sum_q32   = longint'(log10_q32) - Q16_SCALE + longint'(corr);
    // Bias by 64.0 so that the rounding shift works on a non-negative value.
    biased    = longint'(sum_q32 + (64'sd1 << 38));
    biased    = (biased + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    rounded   = longint'(biased) - (64'sd64 << FRAC_BITS);
    if (rounded > MAG_TOP) begin
      rounded = MAG_TOP;
    end
    if (rounded < MAG_BOTTOM) begin
      rounded = MAG_BOTTOM;
    end
    res.magnitude = rounded[MAG_W-1:0];
    return res;
  endfunction

  // Amplitudes mostly have a random bit length, so that every leading-one
  // position turns up; a few are fully random and a few are zero.
  function automatic logic [AMP_W-1:0] pick_amplitude();
    logic [63:0] raw;
    int          len;
    raw = {$urandom, $urandom};
    len = $urandom_range(AMP_W, 1);
    case ($urandom_range(19))
      0: begin
        return '0;
      end
      1, 2, 3: begin
        return raw[AMP_W-1:0];
      end
      default: begin
        return (raw[AMP_W-1:0] & ((40'd1 << len) - 40'd1)) | (40'd1 << (len - 1));
      end
    endcase
  endfunction

  // Distances mostly lie within 1000 km, with some hugging a breakpoint and a
  // few spread over the whole field so that the top bits toggle too.
  function automatic logic [DEG_W-1:0] pick_distance();
    int unsigned base;
    case ($urandom_range(2))
      0: base = 35362;
      1: base = 235752;
      default: base = 589378;
    endcase
    case ($urandom_range(19))
      0, 1: begin
        return DEG_W'($urandom);
      end
      2, 3, 4: begin
        return DEG_W'(base + $urandom_range(6) - 3);
      end
      default: begin
        return DEG_W'($urandom_range(589400, 0));
      end
    endcase
  endfunction

  // Offer one word from a falling edge, after a random gap, and hold it until
  // a rising edge sees ready. Returns at the falling edge after acceptance,
  // with valid still high.
  task automatic send_word(input logic [AMP_W-1:0] amp, input logic [DEG_W-1:0] deg,
                           input bit typed, input ml_result_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    amplitude    <= amp;
    distance_deg <= deg;
    typed_row    <= typed;
    typed_want   <= want;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Lower valid and wait until every outstanding result has been checked. The
  // first wait always advances to the next falling edge, so valid is never
  // assigned twice in the same step.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (magnitude_due_q.size() != 0);
  endtask

  task automatic report_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // The receiver: a long hold-off, counted down here, takes precedence over
  // the random back-pressure of the current mix.
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_ready   <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Both channels are sampled at the rising edge. An accepted input word
  // queues its expected result; an accepted result word is matched against
  // the oldest entry.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        words_in++;
        if (typed_row) begin
          magnitude_due_q.push_back(typed_want);
        end else begin
          magnitude_due_q.push_back(richter_ml(amplitude, distance_deg));
        end
      end
      if (out_valid && out_ready) begin
        words_out++;
        case (status)
          ST_OK:       n_valid++;
          ST_AMP_ZERO: n_zero_amp++;
          default:     n_too_far++;
        endcase
        if (magnitude_due_q.size() == 0) begin
          report_fail($sformatf("result word with nothing expected: magnitude %0d status %0d",
                                magnitude, status));
        end else begin
          oldest_due = magnitude_due_q.pop_front();
          if (magnitude !== oldest_due.magnitude) begin
            report_fail($sformatf("word %0d magnitude expected %0d got %0d", words_out,
                                  oldest_due.magnitude, magnitude));
          end
          if (status !== oldest_due.status) begin
            report_fail($sformatf("word %0d status expected %0d got %0d", words_out,
                                  oldest_due.status, status));
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_cnt,
               magnitude_due_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the first handshake mix.
    send_gap_pct = 36;
    recv_gap_pct = 56;
    for (int i = 0; i < N_DIR; i++) begin
      send_word(DIRECTED[i].amp, DIRECTED[i].deg, DIRECTED[i].typed, DIRECTED[i].want);
    end
    wait_until_drained();

    // Random words in three mixes: a slow receiver, a slow sender, then both
    // at full rate.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 36;
          recv_gap_pct = 56;
        end
        1: begin
          send_gap_pct = 56;
          recv_gap_pct = 36;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
          // Hold the output long enough for every stage to fill while the
          // sender keeps offering words back to back.
          hold_cycles  = 120;
        end
      endcase
      for (int k = 0; k < PHASE_N; k++) begin
        if (ph == 2 && k == 200) begin
          wait_until_drained();
        end
        send_word(pick_amplitude(), pick_distance(), 1'b0, NO_TYPED);
      end
      wait_until_drained();
    end

    // Room for any stray result word to show up.
    repeat (DRAIN) @(negedge clk);

    $display("Checked %0d of %0d words: %0d in range, %0d zero amplitude, %0d too far;",
             words_out, words_in, n_valid, n_zero_amp, n_too_far);
    $display("three handshake mixes, one full-pipeline output stall, %0d cycles.", cycle_cnt);
    if (fail_cnt == 0 && magnitude_due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
